// ===== rtl/weather_sensor_pwm_ook_transmitter_defines.svh =====
// Assertion macros shared by the transmitter RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef WEATHER_SENSOR_PWM_OOK_TRANSMITTER_DEFINES_SVH
`define WEATHER_SENSOR_PWM_OOK_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSOOK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WSOOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/wsook_pkg.sv =====
// Constants and types for the pulse-width OOK weather packet transmitter.
// No dependencies.
`timescale 1ns / 1ps

package wsook_pkg;

  localparam int unsigned PREAMBLE_TOGGLES = 8;
  localparam int unsigned DATA_BIT_COUNT   = 41;
  localparam int unsigned PACKET_W         = 40;
  localparam int unsigned POS_W   = $clog2(PREAMBLE_TOGGLES + DATA_BIT_COUNT + 1);
  localparam int unsigned IDX_W   = $clog2(PACKET_W);

  localparam logic [POS_W-1:0] POS_PREAMBLE_END = POS_W'(PREAMBLE_TOGGLES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PREAMBLE_TOGGLES + DATA_BIT_COUNT);
  localparam logic [POS_W-1:0] POS_PACKET_W = POS_W'(PACKET_W);
  localparam logic [POS_W-1:0] POS_PACKET_MSB = POS_W'(PACKET_W - 1);
  localparam logic [POS_W-1:0] POS_STEP = POS_W'(1);

  localparam logic [1:0] PHASE_LAST = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic signed [11:0] TEMP_MIN   = -12'sd677;
  localparam logic signed [11:0] TEMP_MAX   = 12'sd1590;
  localparam logic [7:0]         HUM_MAX    = 8'd100;
  localparam logic [11:0]        RAW_OFFSET = 12'd1220;  // 320 + 900
  // x/5 == (x * 52429) >> 18 for x below 2^15
  localparam logic [15:0]        DIV5_RECIP = 16'd52429;
  localparam int unsigned        DIV5_SHIFT = 18;

  localparam logic [7:0] RST_SENSOR_ID    = 8'd232;
  localparam logic       RST_BATTERY_LOW  = 1'b0;
  localparam logic       RST_TEST_FLAG    = 1'b1;
  localparam logic [1:0] RST_CHANNEL      = 2'd2;
  localparam logic [3:0] RST_REPEAT_COUNT = 4'd15;

  localparam int unsigned APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SENSOR_ID    = 3'd0,
    REG_BATTERY_LOW  = 3'd1,
    REG_TEST_FLAG    = 3'd2,
    REG_CHANNEL      = 3'd3,
    REG_REPEAT_COUNT = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_BUILT   = 2'd1,
    SEND_INVALID = 2'd2,
    SEND_BUSY    = 2'd3
  } send_result_e;

endpackage

// ===== rtl/weather_sensor_pwm_ook_transmitter.sv =====
// Pulse-width OOK weather packet transmitter: request/tick pipeline and APB registers.
// Depends on wsook_pkg and weather_sensor_pwm_ook_transmitter_defines.svh.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_stall_o   op_i, temperature_i, humidity_i
//   out       source     out_valid_o / out_stall_i tx_level_o, busy_res_o,
//                                                  send_result_o, packet_done_o
//   config    APB        psel/penable/pready       paddr, pwdata, prdata
//
// One word per cycle in and out unless the output stalls; each word is registered
// in the input register, then the result register. Throughput is set by the single
// update stage between them. rst_ni clears the pipeline, the transmitter state and the
// stored packet, and loads the register defaults. A stalled output holds both stages
// once the input register is full; input is taken while that register is empty or the
// result register is free or being drained.
`timescale 1ns / 1ps
`include "weather_sensor_pwm_ook_transmitter_defines.svh"

module weather_sensor_pwm_ook_transmitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [11:0] temperature_i,
  input  logic [7:0]  humidity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_level_o,
  output logic        busy_res_o,
  output logic [1:0]  send_result_o,
  output logic        packet_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [wsook_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [7:0] sensor_id_q;
  logic       battery_low_q;
  logic       test_flag_q;
  logic [1:0] channel_q;
  logic [3:0] repeat_count_q;

  wsook_pkg::reg_idx_e reg_idx;
  logic                cfg_wr;

  // input register
  logic        s1_valid_q;
  logic        s1_op_q;
  logic [11:0] s1_temp_q;
  logic [7:0]  s1_hum_q;

  // result register
  logic       out_valid_q;
  logic       out_level_q;
  logic       out_busy_q;
  logic [1:0] out_result_q;
  logic       out_done_q;

  // transmitter state
  logic [wsook_pkg::PACKET_W-1:0] packet_q, packet_d;
  logic [wsook_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [1:0]                     phase_q, phase_d;
  logic                           bit_val_q, bit_val_d;
  logic [3:0]                     reps_q, reps_d;
  logic                           line_q, line_d;
  logic                           sending_q, sending_d;

  wsook_pkg::send_result_e result_d;
  logic                    done_d;

  logic out_free;
  logic advance;

  assign pready  = 1'b1;
  assign reg_idx = wsook_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      wsook_pkg::REG_SENSOR_ID:    prdata = 32'(sensor_id_q);
      wsook_pkg::REG_BATTERY_LOW:  prdata = 32'(battery_low_q);
      wsook_pkg::REG_TEST_FLAG:    prdata = 32'(test_flag_q);
      wsook_pkg::REG_CHANNEL:      prdata = 32'(channel_q);
      wsook_pkg::REG_REPEAT_COUNT: prdata = 32'(repeat_count_q);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_id_q    <= wsook_pkg::RST_SENSOR_ID;
      battery_low_q  <= wsook_pkg::RST_BATTERY_LOW;
      test_flag_q    <= wsook_pkg::RST_TEST_FLAG;
      channel_q      <= wsook_pkg::RST_CHANNEL;
      repeat_count_q <= wsook_pkg::RST_REPEAT_COUNT;
    end else if (cfg_wr) begin
      case (reg_idx)
        wsook_pkg::REG_SENSOR_ID:    sensor_id_q    <= pwdata[7:0];
        wsook_pkg::REG_BATTERY_LOW:  battery_low_q  <= pwdata[0];
        wsook_pkg::REG_TEST_FLAG:    test_flag_q    <= pwdata[0];
        wsook_pkg::REG_CHANNEL:      channel_q      <= pwdata[1:0];
        wsook_pkg::REG_REPEAT_COUNT: repeat_count_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q   <= op_i;
      s1_temp_q <= temperature_i;
      s1_hum_q  <= humidity_i;
    end
  end

  // raw temperature: trunc(t * 9 / 5) + 1220, mod 4096
  logic        t_neg;
  logic [11:0] t_mag;
  logic [14:0] t_mag9;
  logic [30:0] t_prod;
  logic [11:0] t_quot;
  logic [11:0] raw;
  logic        req_ok;
  logic [7:0]  b0, b1, b2, b3, b4;

  assign t_neg  = s1_temp_q[11];
  assign t_mag  = t_neg ? (12'd0 - s1_temp_q) : s1_temp_q;
  assign t_mag9 = (15'(t_mag) << 3) + 15'(t_mag);
  assign t_prod = 31'(t_mag9) * 31'(wsook_pkg::DIV5_RECIP);
  assign t_quot = t_prod[wsook_pkg::DIV5_SHIFT +: 12];
  assign raw    = t_neg ? (wsook_pkg::RAW_OFFSET - t_quot) : (wsook_pkg::RAW_OFFSET + t_quot);

  assign req_ok = (channel_q != 2'd0) && (s1_hum_q <= wsook_pkg::HUM_MAX) &&
                  ($signed(s1_temp_q) >= wsook_pkg::TEMP_MIN) &&
                  ($signed(s1_temp_q) <= wsook_pkg::TEMP_MAX);

  assign b0 = sensor_id_q;
  assign b1 = {battery_low_q, test_flag_q, channel_q, raw[11:8]};
  assign b2 = raw[7:0];
  assign b3 = s1_hum_q;
  assign b4 = b0 + b1 + b2 + b3;

  // next data bit, zero past the packet end
  logic [wsook_pkg::POS_W-1:0] data_idx;
  logic [wsook_pkg::POS_W-1:0] pkt_sel;
  logic                        data_bit;

  assign data_idx = pos_q - wsook_pkg::POS_PREAMBLE_END;
  assign pkt_sel  = wsook_pkg::POS_PACKET_MSB - data_idx;
  assign data_bit = (data_idx < wsook_pkg::POS_PACKET_W) ?
                    packet_q[pkt_sel[wsook_pkg::IDX_W-1:0]] : 1'b0;

  always_comb begin
    packet_d  = packet_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    bit_val_d = bit_val_q;
    reps_d    = reps_q;
    line_d    = line_q;
    sending_d = sending_q;
    result_d  = wsook_pkg::SEND_NONE;
    done_d    = 1'b0;

    if (s1_op_q == wsook_pkg::OP_SEND) begin
      if (sending_q) begin
        result_d = wsook_pkg::SEND_BUSY;
      end else begin
        if (req_ok) begin
          packet_d = {b0, b1, b2, b3, b4};
          result_d = wsook_pkg::SEND_BUILT;
        end else begin
          result_d = wsook_pkg::SEND_INVALID;
        end
        pos_d     = '0;
        phase_d   = '0;
        line_d    = 1'b0;
        reps_d    = repeat_count_q;
        sending_d = (repeat_count_q != 4'd0);
      end
    end else if (sending_q) begin
      if (phase_q == 2'd0) begin
        if (pos_q >= wsook_pkg::POS_PREAMBLE_END) begin
          bit_val_d = data_bit;
        end
        pos_d  = pos_q + wsook_pkg::POS_STEP;
        line_d = !line_q;
      end else if (pos_q > wsook_pkg::POS_PREAMBLE_END) begin
        // drop the line after one tick for a zero, two for a one
        if ((!bit_val_q && phase_q == 2'd1) || (bit_val_q && phase_q == 2'd2)) begin
          line_d = 1'b0;
          if (pos_q >= wsook_pkg::POS_LAST) begin
            done_d = 1'b1;
          end
        end
      end
      phase_d = (phase_q >= wsook_pkg::PHASE_LAST) ? 2'd0 : phase_q + 2'd1;
      if (done_d) begin
        reps_d    = reps_q - 4'd1;
        pos_d     = '0;
        phase_d   = '0;
        line_d    = 1'b0;
        sending_d = (reps_q != 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_q  <= '0;
      pos_q     <= '0;
      phase_q   <= '0;
      bit_val_q <= 1'b0;
      reps_q    <= '0;
      line_q    <= 1'b0;
      sending_q <= 1'b0;
    end else if (advance) begin
      packet_q  <= packet_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      bit_val_q <= bit_val_d;
      reps_q    <= reps_d;
      line_q    <= line_d;
      sending_q <= sending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q  <= line_d;
      out_busy_q   <= sending_d;
      out_result_q <= result_d;
      out_done_q   <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_level_o    = out_level_q;
  assign busy_res_o    = out_busy_q;
  assign send_result_o = out_result_q;
  assign packet_done_o = out_done_q;

  `WSOOK_ASSERT_IMP(a_phase_range, 1'b1, phase_q != 2'd3)
  `WSOOK_ASSERT_IMP(a_idle_parked, !sending_q,
                    !line_q && phase_q == 2'd0 && pos_q == '0)
  `WSOOK_ASSERT_IMP(a_busy_has_reps, sending_q, reps_q != 4'd0)
  `WSOOK_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= wsook_pkg::POS_LAST)
  `WSOOK_ASSERT_IMP(a_done_line_low, out_valid_o && packet_done_o,
                    !tx_level_o && send_result_o == wsook_pkg::SEND_NONE)
  `WSOOK_ASSERT_NEXT(a_hold_on_stall, in_stall_o, s1_valid_q)

endmodule

// ===== verif/weather_sensor_pwm_ook_transmitter_test.sv =====
// Self-checking bench for the pulse-width OOK weather packet transmitter.
// Drives tick and send words against a local packet/line predictor and programs the APB registers.
// Depends on wsook_pkg and the weather_sensor_pwm_ook_transmitter RTL.
`timescale 1ns / 1ps

module weather_sensor_pwm_ook_transmitter_test;

  // The trailing pad bit is always 0, so a packet ends one tick into its last slot.
  localparam int TICKS_PER_PACKET =
    3 * (wsook_pkg::PREAMBLE_TOGGLES + wsook_pkg::DATA_BIT_COUNT) - 1;

  typedef struct packed {
    logic        op;
    logic [11:0] temp;
    logic [7:0]  hum;
  } req_word_t;

  typedef struct packed {
    logic                    level;
    logic                    busy;
    wsook_pkg::send_result_e result;
    logic                    done;
  } tx_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = wsook_pkg::OP_TICK;
  logic [11:0] temperature_i = '0;
  logic [7:0]  humidity_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        tx_level_o;
  logic        busy_res_o;
  logic [1:0]  send_result_o;
  logic        packet_done_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [wsook_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register copies
  logic [7:0] cfg_sensor_id = wsook_pkg::RST_SENSOR_ID;
  logic       cfg_battery   = wsook_pkg::RST_BATTERY_LOW;
  logic       cfg_test      = wsook_pkg::RST_TEST_FLAG;
  logic [1:0] cfg_channel   = wsook_pkg::RST_CHANNEL;
  logic [3:0] cfg_repeat    = wsook_pkg::RST_REPEAT_COUNT;

  // transmitter state copies
  logic [wsook_pkg::PACKET_W-1:0] packet     = '0;
  logic [wsook_pkg::POS_W-1:0]    bit_pos    = '0;
  logic [1:0]                     tick_phase = '0;
  logic                           cur_bit    = 1'b0;
  logic [3:0]                     reps_left  = '0;
  logic                           line       = 1'b0;
  logic                           tx_active  = 1'b0;

  req_word_t pending_words[$];
  tx_word_t  expected_words[$];
  req_word_t next_word;
  tx_word_t  want_word;
  int        mismatch_count = 0;
  int        result_count = 0;
  int        pushed_count = 0;
  int        send_idle_pct = 28;
  int        recv_stall_pct = 80;

  weather_sensor_pwm_ook_transmitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .temperature_i (temperature_i),
    .humidity_i    (humidity_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_level_o    (tx_level_o),
    .busy_res_o    (busy_res_o),
    .send_result_o (send_result_o),
    .packet_done_o (packet_done_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int got, int want);
    $display("word %0d: %s got %0d expected %0d", result_count, what, got, want);
    mismatch_count++;
  endtask

  // Advance the line state by one accepted word and queue the word it should produce.
  function automatic void predict_tx_word(logic op, logic [11:0] temp, logic [7:0] hum);
    tx_word_t   w;
    int         t_tenths;
    int         scaled;
    int         idx;
    logic [11:0] raw;
    logic [7:0] flags;
    logic [7:0] sum;
    logic       done;
    w.result = wsook_pkg::SEND_NONE;
    done = 1'b0;
    if (op == wsook_pkg::OP_SEND) begin
      if (tx_active) begin
        w.result = wsook_pkg::SEND_BUSY;
      end else begin
        t_tenths = int'($signed(temp));
        if (cfg_channel == 2'd0 || hum > wsook_pkg::HUM_MAX ||
            t_tenths < wsook_pkg::TEMP_MIN || t_tenths > wsook_pkg::TEMP_MAX) begin
          w.result = wsook_pkg::SEND_INVALID;
        end else begin
          scaled = t_tenths * 18 / 10;
          raw = scaled[11:0] + wsook_pkg::RAW_OFFSET;
          flags = {cfg_battery, cfg_test, cfg_channel, raw[11:8]};
          sum = cfg_sensor_id + flags + raw[7:0] + hum;
          packet = {cfg_sensor_id, flags, raw[7:0], hum, sum};
          w.result = wsook_pkg::SEND_BUILT;
        end
        bit_pos = '0;
        tick_phase = '0;
        line = 1'b0;
        reps_left = cfg_repeat;
        tx_active = (cfg_repeat != 4'd0);
      end
    end else if (tx_active) begin
      if (tick_phase == 2'd0) begin
        if (bit_pos >= wsook_pkg::PREAMBLE_TOGGLES) begin
          idx = int'(bit_pos) - wsook_pkg::PREAMBLE_TOGGLES;
          cur_bit = (idx >= wsook_pkg::PACKET_W) ? 1'b0 :
                    packet[wsook_pkg::PACKET_W-1-idx];
        end
        bit_pos = bit_pos + wsook_pkg::POS_STEP;
        line = ~line;
      end else if (bit_pos > wsook_pkg::PREAMBLE_TOGGLES) begin
        // drop the line one tick into the slot for a 0, two ticks for a 1
        if ((!cur_bit && tick_phase == 2'd1) || (cur_bit && tick_phase == 2'd2)) begin
          line = 1'b0;
          if (bit_pos >= wsook_pkg::PREAMBLE_TOGGLES + wsook_pkg::DATA_BIT_COUNT)
            done = 1'b1;
        end
      end
      tick_phase = (tick_phase == wsook_pkg::PHASE_LAST) ? 2'd0 : tick_phase + 2'd1;
      if (done) begin
        if (reps_left != 4'd0) reps_left = reps_left - 4'd1;
        bit_pos = '0;
        tick_phase = '0;
        line = 1'b0;
        if (reps_left == 4'd0) tx_active = 1'b0;
      end
    end
    w.level = line;
    w.busy = tx_active;
    w.done = done;
    expected_words.push_back(w);
  endfunction

  // Driver: hold a stalled word, otherwise present the next pending one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= wsook_pkg::OP_TICK;
      temperature_i <= '0;
      humidity_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_tx_word(op_i, temperature_i, humidity_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          op_i <= next_word.op;
          temperature_i <= next_word.temp;
          humidity_i <= next_word.hum;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each delivered word with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, send_result", send_result_o, 0);
        end else begin
          want_word = expected_words.pop_front();
          if (tx_level_o !== want_word.level)
            report_mismatch("tx_level", tx_level_o, want_word.level);
          if (busy_res_o !== want_word.busy)
            report_mismatch("busy_res", busy_res_o, want_word.busy);
          if (send_result_o !== want_word.result)
            report_mismatch("send_result", send_result_o, want_word.result);
          if (packet_done_o !== want_word.done)
            report_mismatch("packet_done", packet_done_o, want_word.done);
        end
        result_count++;
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic apb_write(wsook_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wsook_pkg::REG_SENSOR_ID:    cfg_sensor_id = value[7:0];
      wsook_pkg::REG_BATTERY_LOW:  cfg_battery = value[0];
      wsook_pkg::REG_TEST_FLAG:    cfg_test = value[0];
      wsook_pkg::REG_CHANNEL:      cfg_channel = value[1:0];
      wsook_pkg::REG_REPEAT_COUNT: cfg_repeat = value[3:0];
      default: ;
    endcase
  endtask

  task automatic write_config(int id, int battery, int test_bit, int channel, int repeats);
    apb_write(wsook_pkg::REG_SENSOR_ID, id);
    apb_write(wsook_pkg::REG_BATTERY_LOW, battery);
    apb_write(wsook_pkg::REG_TEST_FLAG, test_bit);
    apb_write(wsook_pkg::REG_CHANNEL, channel);
    apb_write(wsook_pkg::REG_REPEAT_COUNT, repeats);
  endtask

  // Wait until every word is delivered, then let the pipeline settle.
  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_word(logic op, logic [11:0] temp, logic [7:0] hum);
    pending_words.push_back('{op: op, temp: temp, hum: hum});
    pushed_count++;
  endtask

  // One send word followed by the ticks that carry its whole transmission, with an
  // occasional extra send dropped in while the line is still busy.
  task automatic send_burst(logic [11:0] temp, logic [7:0] hum);
    int n_ticks;
    int busy_at;
    push_word(wsook_pkg::OP_SEND, temp, hum);
    n_ticks = (cfg_repeat == 4'd0) ? $urandom_range(0, 3) : cfg_repeat * TICKS_PER_PACKET;
    busy_at = $urandom_range(0, 2 * n_ticks);
    for (int i = 0; i < n_ticks; i++) begin
      if (i == busy_at && i < n_ticks - 1 && cfg_repeat != 4'd0)
        push_word(wsook_pkg::OP_SEND, 12'($urandom_range(0, 4095)),
                  8'($urandom_range(0, 255)));
      push_word(wsook_pkg::OP_TICK, 12'($urandom_range(0, 4095)),
                8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 3))
      push_word(wsook_pkg::OP_TICK, 12'($urandom_range(0, 4095)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(int budget);
    int start;
    start = pushed_count;
    while (pushed_count - start < budget) begin
      if ($urandom_range(0, 3) != 0)
        send_burst(12'($urandom_range(0, 2267) - 677), 8'($urandom_range(0, 100)));
      else
        send_burst(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic set_idling(int phase_idx);
    if (phase_idx < 3) begin
      send_idle_pct = 28;
      recv_stall_pct = 80;
    end else if (phase_idx < 6) begin
      send_idle_pct = 80;
      recv_stall_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle ticks, field extremes and the zero packet after reset
    set_idling(0);
    write_config(255, 1, 1, 3, 1);
    push_word(wsook_pkg::OP_TICK, 12'hFFF, 8'hFF);
    push_word(wsook_pkg::OP_TICK, 12'h000, 8'h00);
    send_burst(12'd0, 8'd101);                // nothing built yet: zero packet goes out
    send_burst(12'($signed(-677)), 8'd0);
    send_burst(12'd1590, 8'd100);
    wait_drained();

    // zero repeats: each request only returns its status, the last one builds a packet
    write_config(255, 1, 1, 3, 0);
    send_burst(12'($signed(-678)), 8'd50);
    send_burst(12'd1591, 8'd50);
    send_burst(12'h800, 8'd0);
    send_burst(12'h7FF, 8'd0);
    send_burst(12'd250, 8'd255);
    send_burst(12'd0, 8'd50);
    wait_drained();

    // an invalid request sends the packet built above
    write_config(255, 1, 1, 3, 1);
    send_burst(12'd0, 8'd101);
    wait_drained();

    set_idling(1);
    write_config(0, 0, 0, 1, 2);
    random_phase(1);
    wait_drained();

    set_idling(2);
    write_config(0, 1, 0, 2, 1);
    random_phase(1);
    wait_drained();

    // channel zero rejects every request, the old packet still goes out
    set_idling(3);
    write_config($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1), 0, 1);
    random_phase(1);
    wait_drained();

    // zero repeats: a valid request builds the packet but the line stays quiet
    set_idling(4);
    write_config($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(1, 3), 0);
    random_phase(40);
    wait_drained();

    for (int p = 5; p < 8; p++) begin
      set_idling(p);
      write_config($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(1, 3), $urandom_range(1, 2));
      random_phase(140);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsook_pkg.sv
rtl/weather_sensor_pwm_ook_transmitter.sv
verif/weather_sensor_pwm_ook_transmitter_test.sv
